// ----- hdl/ivs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivs_pkg
// Shared sizes, operation codes, status codes and FSM state codes of the indexed value stack.
// ----------------------------------------------------------------------------
package ivs_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int WORD_BITS   = 64;
  localparam int ADDR_BITS   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
  localparam int CMP_BITS    = (CNT_BITS > 10) ? CNT_BITS + 1 : 11;
  localparam int LEFT_BITS   = 8;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_READ    = 2'd2,
    OP_REVERSE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ARG  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE   = 3'b001,
    FSM_SWAP_A = 3'b010,
    FSM_SWAP_B = 3'b100
  } fsm_e;

endpackage

// ----- hdl/ivs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivs_ram
// Synchronous RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ivs_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ----- hdl/indexed_value_stack_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_value_stack_core
// Value stack with push, multi-word pop, indexed read and range reverse.
// ----------------------------------------------------------------------------
// Push, pop, read and short or failed reverse: result in the next cycle; while
// idle, a new word accepted every cycle (read data from the RAM read port).
// Reverse of n >= 2 entries: busy for floor(n/2) swaps, each through states
// SWAP_A then SWAP_B (RAM write port), result in the cycle busy falls.
// Results are strobed on done_o for one cycle; the receiver cannot stall.
// Reset empties the stack; no clearing pass, entries are written before read.
// ----------------------------------------------------------------------------
module indexed_value_stack_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] push_word_i,
  input  logic [7:0]  position_i,
  input  logic [8:0]  amount_i,
  output logic        done_o,
  output logic [63:0] read_word_o,
  output logic [8:0]  stack_size_o,
  output logic [1:0]  status_o
);

  import ivs_pkg::*;

  fsm_e                 state_q, state_d;
  logic [CNT_BITS-1:0]  fill_q, fill_d;
  logic                 done_q, done_d;
  status_e              status_q, status_d;
  logic                 rd_sel_q, rd_sel_d;
  logic [ADDR_BITS-1:0] hi_q, hi_d, lo_q, lo_d;
  logic [LEFT_BITS-1:0] left_q, left_d;
  logic [WORD_BITS-1:0] hold_q, hold_d;

  logic                 accept;
  op_e                  op;
  logic [CMP_BITS-1:0]  fill_x, pos_x, amt_x, end_x;
  logic                 full, pos_bad, range_bad, pop_bad;
  logic [ADDR_BITS-1:0] slot_top, slot_end;

  logic                 we;
  logic [ADDR_BITS-1:0] waddr, raddr_a, raddr_b;
  logic [WORD_BITS-1:0] wdata, rdata_a, rdata_b;

  assign accept    = start_i && (state_q == FSM_IDLE);
  assign op        = op_e'(operation_i);
  assign fill_x    = CMP_BITS'(fill_q);
  assign pos_x     = CMP_BITS'(position_i);
  assign amt_x     = CMP_BITS'(amount_i);
  assign end_x     = pos_x + amt_x;
  assign full      = (fill_q == CNT_BITS'(STACK_DEPTH));
  assign pos_bad   = (pos_x >= fill_x);
  assign range_bad = (end_x > fill_x);
  assign pop_bad   = (amt_x > fill_x);

  // slot = fill - 1 - depth
  always_comb begin
    logic [CMP_BITS-1:0] s_top, s_end;
    s_top    = fill_x - CMP_BITS'(1) - pos_x;
    s_end    = fill_x - end_x;
    slot_top = s_top[ADDR_BITS-1:0];
    slot_end = s_end[ADDR_BITS-1:0];
  end

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    done_d   = 1'b0;
    status_d = status_q;
    rd_sel_d = 1'b0;
    hi_d     = hi_q;
    lo_d     = lo_q;
    left_d   = left_q;
    hold_d   = hold_q;
    we       = 1'b0;
    waddr    = fill_q[ADDR_BITS-1:0];
    wdata    = push_word_i[WORD_BITS-1:0];
    raddr_a  = slot_top;
    raddr_b  = slot_end;

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          case (op)
            OP_PUSH: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                we     = 1'b1;
                fill_d = fill_q + CNT_BITS'(1);
              end
            end
            OP_POP: begin
              if (pop_bad) begin
                status_d = ST_ARG;
              end else begin
                fill_d = CNT_BITS'(fill_x - amt_x);
              end
            end
            OP_READ: begin
              if (pos_bad) begin
                status_d = ST_ARG;
              end else begin
                rd_sel_d = 1'b1;
              end
            end
            OP_REVERSE: begin
              if (range_bad) begin
                status_d = ST_ARG;
              end else if (amount_i > 9'd1) begin
                done_d  = 1'b0;
                hi_d    = slot_top;
                lo_d    = slot_end;
                left_d  = amount_i[8:1];
                state_d = FSM_SWAP_A;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_SWAP_A: begin
        we      = 1'b1;
        waddr   = hi_q;
        wdata   = rdata_b;
        hold_d  = rdata_a;
        state_d = FSM_SWAP_B;
      end
      FSM_SWAP_B: begin
        we      = 1'b1;
        waddr   = lo_q;
        wdata   = hold_q;
        raddr_a = hi_q - ADDR_BITS'(1);
        raddr_b = lo_q + ADDR_BITS'(1);
        if (left_q > LEFT_BITS'(1)) begin
          hi_d    = hi_q - ADDR_BITS'(1);
          lo_d    = lo_q + ADDR_BITS'(1);
          left_d  = left_q - LEFT_BITS'(1);
          state_d = FSM_SWAP_A;
        end else begin
          done_d   = 1'b1;
          status_d = ST_OK;
          state_d  = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      fill_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      rd_sel_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      done_q   <= done_d;
      status_q <= status_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    left_q <= left_d;
    hold_q <= hold_d;
  end

  ivs_ram #(
    .DEPTH  (STACK_DEPTH),
    .WIDTH  (WORD_BITS),
    .ADDR_W (ADDR_BITS)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign busy_o       = (state_q != FSM_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign stack_size_o = 9'(fill_q);
  assign read_word_o  = rd_sel_q ? 64'(rdata_a) : 64'd0;

endmodule

// ----- hdl/ivs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivs_checker
// Port-level checks of the indexed value stack, bound to the top level.
// ----------------------------------------------------------------------------
module ivs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  operation_i,
  input logic        done_o,
  input logic [63:0] read_word_o,
  input logic [8:0]  stack_size_o,
  input logic [1:0]  status_o
);

  import ivs_pkg::*;

  // push, pop and read answer in the next cycle
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (operation_i != OP_REVERSE)) |=> done_o)
    else $error("missing result after single-word op");

  a_no_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("result strobed during reverse");

  a_error_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (read_word_o == 64'd0))
    else $error("non-zero word on error");

  a_full_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (stack_size_o == 9'(STACK_DEPTH)))
    else $error("full status with stack not full");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (stack_size_o <= 9'(STACK_DEPTH)))
    else $error("size beyond depth");

endmodule

bind indexed_value_stack_core ivs_checker u_ivs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .operation_i  (operation_i),
  .done_o       (done_o),
  .read_word_o  (read_word_o),
  .stack_size_o (stack_size_o),
  .status_o     (status_o)
);
